>>> src/icdt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// icdt_pkg
// Shared types and constants for the IUPAC codon translator: base masks,
// position kinds, amino-acid codes and the standard genetic code.
// ---------------------------------------------------------------------------
package icdt_pkg;

  // base mask bits, ordered T C A G
  localparam int BitT = 0;
  localparam int BitC = 1;
  localparam int BitA = 2;
  localparam int BitG = 3;

  typedef logic [3:0] base_mask_t;
  typedef logic [7:0] ascii_t;
  typedef logic [6:0] amino_t;
  typedef logic [1:0] codon_pos_t;

  typedef struct packed {
    base_mask_t first;
    base_mask_t second;
    base_mask_t third;
  } codon_masks_t;

  // position kinds
  localparam codon_pos_t POS_MIDDLE = 2'd0;
  localparam codon_pos_t POS_BEGIN  = 2'd1;
  localparam codon_pos_t POS_END    = 2'd2;
  localparam codon_pos_t POS_UNUSED = 2'd3;

  // IUPAC input letters
  localparam ascii_t CH_A    = 8'h41;
  localparam ascii_t CH_C    = 8'h43;
  localparam ascii_t CH_G    = 8'h47;
  localparam ascii_t CH_T    = 8'h54;
  localparam ascii_t CH_U    = 8'h55;
  localparam ascii_t CH_R    = 8'h52;
  localparam ascii_t CH_Y    = 8'h59;
  localparam ascii_t CH_S    = 8'h53;
  localparam ascii_t CH_W    = 8'h57;
  localparam ascii_t CH_K    = 8'h4B;
  localparam ascii_t CH_M    = 8'h4D;
  localparam ascii_t CH_B    = 8'h42;
  localparam ascii_t CH_D    = 8'h44;
  localparam ascii_t CH_H    = 8'h48;
  localparam ascii_t CH_V    = 8'h56;
  localparam ascii_t CH_N    = 8'h4E;
  localparam ascii_t CH_DASH = 8'h2D;

  // special result letters
  localparam amino_t LTR_X    = 7'h58;
  localparam amino_t LTR_M    = 7'h4D;
  localparam amino_t LTR_STOP = 7'h2A;
  localparam amino_t LTR_GAP  = 7'h2D;

  // amino-acid codes, one per distinct letter of the code table
  localparam int NumAa = 21;
  typedef logic [4:0] aa_idx_t;
  typedef logic [NumAa-1:0] aa_set_t;

  localparam aa_idx_t AA_F    = 5'd0;
  localparam aa_idx_t AA_L    = 5'd1;
  localparam aa_idx_t AA_S    = 5'd2;
  localparam aa_idx_t AA_Y    = 5'd3;
  localparam aa_idx_t AA_STOP = 5'd4;
  localparam aa_idx_t AA_C    = 5'd5;
  localparam aa_idx_t AA_W    = 5'd6;
  localparam aa_idx_t AA_P    = 5'd7;
  localparam aa_idx_t AA_H    = 5'd8;
  localparam aa_idx_t AA_Q    = 5'd9;
  localparam aa_idx_t AA_R    = 5'd10;
  localparam aa_idx_t AA_I    = 5'd11;
  localparam aa_idx_t AA_M    = 5'd12;
  localparam aa_idx_t AA_T    = 5'd13;
  localparam aa_idx_t AA_N    = 5'd14;
  localparam aa_idx_t AA_K    = 5'd15;
  localparam aa_idx_t AA_V    = 5'd16;
  localparam aa_idx_t AA_A    = 5'd17;
  localparam aa_idx_t AA_D    = 5'd18;
  localparam aa_idx_t AA_E    = 5'd19;
  localparam aa_idx_t AA_G    = 5'd20;

  localparam amino_t AMINO_ASCII [NumAa] = '{
    7'h46, 7'h4C, 7'h53, 7'h59, 7'h2A, 7'h43, 7'h57, 7'h50, 7'h48, 7'h51, 7'h52,
    7'h49, 7'h4D, 7'h54, 7'h4E, 7'h4B, 7'h56, 7'h41, 7'h44, 7'h45, 7'h47
  };

  // standard code, index first*16 + second*4 + third, bases ordered T C A G
  localparam aa_idx_t CODE_TABLE [64] = '{
    AA_F, AA_F, AA_L, AA_L, AA_S, AA_S, AA_S, AA_S,
    AA_Y, AA_Y, AA_STOP, AA_STOP, AA_C, AA_C, AA_STOP, AA_W,
    AA_L, AA_L, AA_L, AA_L, AA_P, AA_P, AA_P, AA_P,
    AA_H, AA_H, AA_Q, AA_Q, AA_R, AA_R, AA_R, AA_R,
    AA_I, AA_I, AA_I, AA_M, AA_T, AA_T, AA_T, AA_T,
    AA_N, AA_N, AA_K, AA_K, AA_S, AA_S, AA_R, AA_R,
    AA_V, AA_V, AA_V, AA_V, AA_A, AA_A, AA_A, AA_A,
    AA_D, AA_D, AA_E, AA_E, AA_G, AA_G, AA_G, AA_G
  };

endpackage

`default_nettype wire

>>> src/iupac_codon_translator_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iupac_codon_translator_core
// Translates one codon of three IUPAC ASCII letters into one amino-acid letter.
// ---------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries three codon letters and the
//   position kind (0 middle, 1 first codon, 2 last codon, 3 gives X)
//   output channel out_valid/out_ready returns the amino-acid letter, with
//   * for stop, - for the gap codon and X for anything untranslatable
// Stages: one stage is the input register and one the result register; an
//   accepted codon moves on to the result register once that is free, and
//   out_valid rises when the result register loads its letter.
// Throughput: one transaction per cycle while out_ready is high; a whole
//   translation is one decode and code-table pass between the two registers.
// Stall: when out_ready is low the result register holds its letter, the
//   input register still fills, and in_ready drops only when both are full.
// Reset: synchronous active-low rst_n empties both stages; no result is
//   presented and the first transaction may be sent in the following cycle.
// ---------------------------------------------------------------------------
module iupac_codon_translator_core (
  input  wire  logic                 clk,
  input  wire  logic                 rst_n,
  input  wire  logic                 in_valid,
  output       logic                 in_ready,
  input  wire  icdt_pkg::ascii_t     in_base_first,
  input  wire  icdt_pkg::ascii_t     in_base_second,
  input  wire  icdt_pkg::ascii_t     in_base_third,
  input  wire  icdt_pkg::codon_pos_t in_codon_position,
  output       logic                 out_valid,
  input  wire  logic                 out_ready,
  output       icdt_pkg::amino_t     out_amino_letter
);
  import icdt_pkg::*;

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  ascii_t       s1_first_r;
  ascii_t       s1_second_r;
  ascii_t       s1_third_r;
  codon_pos_t   s1_pos_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  amino_t       out_letter_r;
  logic         s1_adv;
  logic         in_fire;
  base_mask_t   mask_first;
  base_mask_t   mask_second;
  base_mask_t   mask_third;
  codon_masks_t masks;
  logic         is_gap;
  amino_t       amino;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  icdt_base_decode u_dec_first  (.letter(s1_first_r),  .mask(mask_first));
  icdt_base_decode u_dec_second (.letter(s1_second_r), .mask(mask_second));
  icdt_base_decode u_dec_third  (.letter(s1_third_r),  .mask(mask_third));

  assign masks = {mask_first, mask_second, mask_third};

  assign is_gap = (s1_first_r == CH_DASH) && (s1_second_r == CH_DASH) &&
                  (s1_third_r == CH_DASH);

  icdt_translate u_translate (
    .masks    (masks),
    .is_gap   (is_gap),
    .position (s1_pos_r),
    .amino    (amino)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_r  <= in_base_first;
      s1_second_r <= in_base_second;
      s1_third_r  <= in_base_third;
      s1_pos_r    <= in_codon_position;
    end
    if (s1_adv) begin
      out_letter_r <= amino;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_amino_letter = out_letter_r;

`ifndef SYNTHESIS
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("translated codon did not reach the result register");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while a stage was free");

  a_unused_pos_gives_x: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_pos_r == POS_UNUSED) |=> (out_amino_letter == LTR_X))
    else $error("unused position kind did not give X");
`endif

endmodule

`default_nettype wire

>>> src/icdt_base_decode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// icdt_base_decode
// Maps one ASCII IUPAC letter to its base mask over T C A G; U reads as T,
// anything unrecognized gives an empty mask.
// ---------------------------------------------------------------------------
module icdt_base_decode (
  input  wire  icdt_pkg::ascii_t     letter,
  output icdt_pkg::base_mask_t       mask
);
  import icdt_pkg::*;

  always_comb begin
    mask = '0;
    case (letter)
      CH_A: mask[BitA] = 1'b1;
      CH_C: mask[BitC] = 1'b1;
      CH_G: mask[BitG] = 1'b1;
      CH_T, CH_U: mask[BitT] = 1'b1;
      CH_R: begin mask[BitA] = 1'b1; mask[BitG] = 1'b1; end
      CH_Y: begin mask[BitC] = 1'b1; mask[BitT] = 1'b1; end
      CH_S: begin mask[BitG] = 1'b1; mask[BitC] = 1'b1; end
      CH_W: begin mask[BitA] = 1'b1; mask[BitT] = 1'b1; end
      CH_K: begin mask[BitG] = 1'b1; mask[BitT] = 1'b1; end
      CH_M: begin mask[BitA] = 1'b1; mask[BitC] = 1'b1; end
      CH_B: begin mask[BitC] = 1'b1; mask[BitG] = 1'b1; mask[BitT] = 1'b1; end
      CH_D: begin mask[BitA] = 1'b1; mask[BitG] = 1'b1; mask[BitT] = 1'b1; end
      CH_H: begin mask[BitA] = 1'b1; mask[BitC] = 1'b1; mask[BitT] = 1'b1; end
      CH_V: begin mask[BitA] = 1'b1; mask[BitC] = 1'b1; mask[BitG] = 1'b1; end
      CH_N: mask = '1;
      default: mask = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/icdt_translate.sv
`default_nettype none
// ---------------------------------------------------------------------------
// icdt_translate
// Turns the three base masks of a codon and its position kind into one
// amino-acid letter: start/stop overrides, gap, and ambiguous-code consensus.
// ---------------------------------------------------------------------------
module icdt_translate (
  input  wire  icdt_pkg::codon_masks_t masks,
  input  wire  logic                   is_gap,
  input  wire  icdt_pkg::codon_pos_t   position,
  output icdt_pkg::amino_t             amino
);
  import icdt_pkg::*;

  aa_set_t hit;
  aa_set_t hit_less;
  logic    single;
  amino_t  agreed;
  logic    all_valid;
  logic    can_start;
  logic    can_stop;

  // mark every amino acid reached by some expansion of the codon
  always_comb begin
    hit = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          if (masks.first[i] && masks.second[j] && masks.third[k]) begin
            hit[CODE_TABLE[6'(i * 16 + j * 4 + k)]] = 1'b1;
          end
        end
      end
    end
  end

  assign hit_less = hit - aa_set_t'(1);
  assign single   = (hit != '0) && ((hit & hit_less) == '0);

  always_comb begin
    agreed = '0;
    for (int n = 0; n < NumAa; n++) begin
      if (hit[n]) begin
        agreed = agreed | AMINO_ASCII[n];
      end
    end
  end

  assign all_valid = (masks.first != '0) && (masks.second != '0) && (masks.third != '0);

  // ATG, TTG, CTG
  assign can_start = (masks.first[BitA] || masks.first[BitC] || masks.first[BitT]) &&
                     masks.second[BitT] && masks.third[BitG];
  // TAA, TAG, TGA
  assign can_stop  = masks.first[BitT] &&
                     ((masks.second[BitA] && (masks.third[BitA] || masks.third[BitG])) ||
                      (masks.second[BitG] && masks.third[BitA]));

  always_comb begin
    if (position == POS_UNUSED) begin
      amino = LTR_X;
    end else if (is_gap) begin
      amino = LTR_GAP;
    end else if (!all_valid) begin
      amino = LTR_X;
    end else if (position == POS_BEGIN && can_start) begin
      amino = LTR_M;
    end else if (position == POS_END && can_stop) begin
      amino = LTR_STOP;
    end else if (single) begin
      amino = agreed;
    end else begin
      amino = LTR_X;
    end
  end

endmodule

`default_nettype wire
